/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the dispatcher core, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* design/ppd_pkg.sv */
// ----------------------------------------------------------------------------
// ppd_pkg
// shared types and constants of the periodic priority task dispatcher
// ----------------------------------------------------------------------------
package ppd_pkg;

    // default sizes
    localparam int SLOTS_DEF      = 16;
    localparam int PRIORITIES_DEF = 8;

    // field widths
    localparam int PRIO_W   = 4;
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 64;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int RAN_W    = 5;
    localparam int STAT_W   = 2;

    // add status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVAL = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_ROUND = 1'b1;

    // one task table entry
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic [CNT_W-1:0]    runs;
    } t_entry;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

/* design/ppd_ram.sv */
// ----------------------------------------------------------------------------
// ppd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/periodic_priority_task_dispatcher_core.sv */
// ----------------------------------------------------------------------------
// periodic_priority_task_dispatcher_core
// task table in one ram; adds write a slot, rounds scan priority by slot
// ----------------------------------------------------------------------------
// add beat: result strobed the next cycle, busy stays low
// round beat: one ram read per (priority, slot) pair over the used slots;
//   an empty table answers the next cycle
// each dispatch beat waits for the next hit or the end of the scan, no stalls
// synchronous active-low reset clears the slot count, counters and control
`include "assert_macros.svh"

module periodic_priority_task_dispatcher_core #(
    parameter int SLOTS      = ppd_pkg::SLOTS_DEF,
    parameter int PRIORITIES = ppd_pkg::PRIORITIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [ppd_pkg::TIME_W-1:0]   i_current_time,
    input  logic [ppd_pkg::PRIO_W-1:0]   i_task_priority_in,
    input  logic [ppd_pkg::PERIOD_W-1:0] i_task_period_in,
    input  logic                         i_has_handler,
    output logic                         o_valid,
    output logic [ppd_pkg::STAT_W-1:0]   o_status,
    output logic                         o_dispatched,
    output logic [ppd_pkg::SLOT_W-1:0]   o_task_slot,
    output logic [ppd_pkg::CNT_W-1:0]    o_task_run_count,
    output logic [ppd_pkg::RAN_W-1:0]    o_ran_in_round,
    output logic [ppd_pkg::CNT_W-1:0]    o_round_total,
    output logic [ppd_pkg::CNT_W-1:0]    o_idle_round_total,
    output logic [ppd_pkg::CNT_W-1:0]    o_dispatch_total,
    output logic                         o_last
);
    import ppd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);
    localparam int EW = $bits(t_entry);

    localparam logic [UW-1:0]     SLOTS_U  = UW'(SLOTS);
    localparam logic [PRIO_W:0]   PRIO_LIM = (PRIO_W + 1)'(PRIORITIES);
    localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(PRIORITIES - 1);

    // control and counters
    t_state              r_state, n_state;
    logic [UW-1:0]       r_used, n_used;
    logic [CNT_W-1:0]    r_rounds, n_rounds;
    logic [CNT_W-1:0]    r_idle, n_idle;
    logic [CNT_W-1:0]    r_disp, n_disp;

    // scan position and round time
    logic [TIME_W-1:0]   r_now, n_now;
    logic [PRIO_W-1:0]   r_p, n_p;
    logic [SW-1:0]       r_i, n_i;
    logic [UW-1:0]       r_n, n_n;

    // data stage, registered in step with the ram read data
    logic                r_dv, n_dv;
    logic [SW-1:0]       r_ds, n_ds;
    logic [PRIO_W-1:0]   r_dp, n_dp;

    // pending dispatch, held until its last flag is known
    logic                r_pv, n_pv;
    logic [SW-1:0]       r_pslot, n_pslot;
    logic [CNT_W-1:0]    r_pruns, n_pruns;
    logic [UW-1:0]       r_pran, n_pran;
    logic [CNT_W-1:0]    r_ptot, n_ptot;

    // result registers
    logic                r_ov, n_ov;
    logic [STAT_W-1:0]   r_ostat, n_ostat;
    logic                r_odisp, n_odisp;
    logic [SLOT_W-1:0]   r_oslot, n_oslot;
    logic [CNT_W-1:0]    r_oruns, n_oruns;
    logic [RAN_W-1:0]    r_oran, n_oran;
    logic [CNT_W-1:0]    r_orounds, n_orounds;
    logic [CNT_W-1:0]    r_oidle, n_oidle;
    logic [CNT_W-1:0]    r_odtot, n_odtot;
    logic                r_olast, n_olast;

    // ram ports
    logic                ram_we;
    logic [SW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    logic [EW-1:0]       ram_rbits;

    // add path
    logic [STAT_W-1:0]   add_stat;
    logic [PERIOD_W-1:0] add_step;
    // due check path
    logic [TIME_W-1:0]   due_diff;
    logic [PERIOD_W-1:0] due_step;
    logic                hit;
    logic [SW-1:0]       last_slot;

    // task table: one entry per slot
    ppd_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_i),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_entry'(ram_rbits);
    assign busy      = (r_state != S_IDLE);
    assign last_slot = SW'(r_used - UW'(1));

    // add status and first deadline step
    always_comb begin
        if (!i_has_handler || ({1'b0, i_task_priority_in} >= PRIO_LIM)) begin
            add_stat = ST_INVAL;
        end else if (r_used >= SLOTS_U) begin
            add_stat = ST_FULL;
        end else begin
            add_stat = ST_OK;
        end
        add_step = (i_task_period_in != '0) ? i_task_period_in : PERIOD_W'(1);
    end

    // due test on the entry read back; a slot matches one priority only,
    // so its single writeback per round never meets a later read that counts
    always_comb begin
        due_diff = r_now - ram_rdata.deadline;
        due_step = (ram_rdata.period != '0) ? ram_rdata.period : PERIOD_W'(1);
        hit      = r_dv && (ram_rdata.prio == r_dp) &&
                   ((ram_rdata.period == '0) || !due_diff[TIME_W-1]);
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_rounds  = r_rounds;
        n_idle    = r_idle;
        n_disp    = r_disp;
        n_now     = r_now;
        n_p       = r_p;
        n_i       = r_i;
        n_n       = r_n;
        n_dv      = 1'b0;
        n_ds      = r_ds;
        n_dp      = r_dp;
        n_pv      = r_pv;
        n_pslot   = r_pslot;
        n_pruns   = r_pruns;
        n_pran    = r_pran;
        n_ptot    = r_ptot;
        n_ov      = 1'b0;
        n_ostat   = r_ostat;
        n_odisp   = r_odisp;
        n_oslot   = r_oslot;
        n_oruns   = r_oruns;
        n_oran    = r_oran;
        n_orounds = r_orounds;
        n_oidle   = r_oidle;
        n_odtot   = r_odtot;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_ds;
        ram_wdata = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_ADD) begin
                        // add beat: one result, table write on success
                        n_ov      = 1'b1;
                        n_ostat   = add_stat;
                        n_odisp   = 1'b0;
                        n_oslot   = '0;
                        n_oruns   = '0;
                        n_oran    = '0;
                        n_orounds = r_rounds;
                        n_oidle   = r_idle;
                        n_odtot   = r_disp;
                        n_olast   = 1'b1;
                        if (add_stat == ST_OK) begin
                            n_oslot            = SLOT_W'(r_used);
                            ram_we             = 1'b1;
                            ram_waddr          = r_used[SW-1:0];
                            ram_wdata.prio     = i_task_priority_in;
                            ram_wdata.period   = i_task_period_in;
                            ram_wdata.deadline = i_current_time + TIME_W'(add_step);
                            ram_wdata.runs     = '0;
                            n_used             = r_used + UW'(1);
                        end
                    end else begin
                        // round beat
                        n_rounds = r_rounds + CNT_W'(1);
                        if (r_used == '0) begin
                            n_idle    = r_idle + CNT_W'(1);
                            n_ov      = 1'b1;
                            n_ostat   = ST_OK;
                            n_odisp   = 1'b0;
                            n_oslot   = '0;
                            n_oruns   = '0;
                            n_oran    = '0;
                            n_orounds = r_rounds + CNT_W'(1);
                            n_oidle   = r_idle + CNT_W'(1);
                            n_odtot   = r_disp;
                            n_olast   = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                            n_now   = i_current_time;
                            n_p     = '0;
                            n_i     = '0;
                            n_n     = '0;
                            n_pv    = 1'b0;
                        end
                    end
                end
            end
            S_SCAN: begin
                // issue one read per (priority, slot) pair
                n_dv = 1'b1;
                n_ds = r_i;
                n_dp = r_p;
                if (r_i == last_slot) begin
                    n_i = '0;
                    if (r_p == PRIO_TOP) begin
                        n_state = S_DONE;
                    end else begin
                        n_p = r_p + PRIO_W'(1);
                    end
                end else begin
                    n_i = r_i + SW'(1);
                end
            end
            S_DONE: begin
                // flush once the final read has been checked
                if (!r_dv) begin
                    n_state   = S_IDLE;
                    n_ov      = 1'b1;
                    n_ostat   = ST_OK;
                    n_orounds = r_rounds;
                    n_olast   = 1'b1;
                    if (r_pv) begin
                        n_odisp = 1'b1;
                        n_oslot = SLOT_W'(r_pslot);
                        n_oruns = r_pruns;
                        n_oran  = RAN_W'(r_pran);
                        n_oidle = r_idle;
                        n_odtot = r_ptot;
                    end else begin
                        n_idle  = r_idle + CNT_W'(1);
                        n_odisp = 1'b0;
                        n_oslot = '0;
                        n_oruns = '0;
                        n_oran  = '0;
                        n_oidle = r_idle + CNT_W'(1);
                        n_odtot = r_disp;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // dispatch: write back, release the previous pending hit
        if (hit) begin
            ram_we             = 1'b1;
            ram_waddr          = r_ds;
            ram_wdata.deadline = r_now + TIME_W'(due_step);
            ram_wdata.runs     = ram_rdata.runs + CNT_W'(1);
            n_disp             = r_disp + CNT_W'(1);
            n_n                = r_n + UW'(1);
            if (r_pv) begin
                n_ov      = 1'b1;
                n_ostat   = ST_OK;
                n_odisp   = 1'b1;
                n_oslot   = SLOT_W'(r_pslot);
                n_oruns   = r_pruns;
                n_oran    = RAN_W'(r_pran);
                n_orounds = r_rounds;
                n_oidle   = r_idle;
                n_odtot   = r_ptot;
                n_olast   = 1'b0;
            end
            n_pv    = 1'b1;
            n_pslot = r_ds;
            n_pruns = ram_rdata.runs + CNT_W'(1);
            n_pran  = r_n + UW'(1);
            n_ptot  = r_disp + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_rounds <= '0;
            r_idle   <= '0;
            r_disp   <= '0;
            r_dv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_rounds <= n_rounds;
            r_idle   <= n_idle;
            r_disp   <= n_disp;
            r_dv     <= n_dv;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_p       <= n_p;
        r_i       <= n_i;
        r_n       <= n_n;
        r_ds      <= n_ds;
        r_dp      <= n_dp;
        r_pslot   <= n_pslot;
        r_pruns   <= n_pruns;
        r_pran    <= n_pran;
        r_ptot    <= n_ptot;
        r_ostat   <= n_ostat;
        r_odisp   <= n_odisp;
        r_oslot   <= n_oslot;
        r_oruns   <= n_oruns;
        r_oran    <= n_oran;
        r_orounds <= n_orounds;
        r_oidle   <= n_oidle;
        r_odtot   <= n_odtot;
        r_olast   <= n_olast;
    end

    assign o_valid            = r_ov;
    assign o_status           = r_ostat;
    assign o_dispatched       = r_odisp;
    assign o_task_slot        = r_oslot;
    assign o_task_run_count   = r_oruns;
    assign o_ran_in_round     = r_oran;
    assign o_round_total      = r_orounds;
    assign o_idle_round_total = r_oidle;
    assign o_dispatch_total   = r_odtot;
    assign o_last             = r_olast;

    // checks
    `ASSERT_IMPLY(a_nodisp_last, i_clk, i_rst_n, r_ov && !r_odisp, r_olast, "non-dispatch beat not last")
    `ASSERT_IMPLY(a_disp_ran, i_clk, i_rst_n, r_ov && r_odisp, r_oran != '0, "dispatch beat with zero ran count")
    `ASSERT_IMPLY(a_stage_busy, i_clk, i_rst_n, r_dv, r_state != S_IDLE, "read data stage active while idle")
    `ASSERT_NEVER(a_used_max, i_clk, i_rst_n, r_used > SLOTS_U, "slot count beyond table size")

endmodule
